### rtl/c2d_pkg.sv
// shared constants and types for the conv2d bias relu block
package c2d_pkg;

   localparam int IMAGE_SIZE   = 32;
   localparam int IN_CHANNELS  = 1;
   localparam int OUT_CHANNELS = 6;
   localparam int KERNEL_SIZE  = 5;
   localparam int DATA_WIDTH   = 16;

   localparam int OUT_SIZE   = IMAGE_SIZE - KERNEL_SIZE + 1;
   localparam int FEAT_DEPTH = IMAGE_SIZE * IMAGE_SIZE * IN_CHANNELS;
   localparam int WGT_DEPTH  = KERNEL_SIZE * KERNEL_SIZE * IN_CHANNELS * OUT_CHANNELS;
   localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE * IN_CHANNELS;

   localparam int FEAT_AW = $clog2(FEAT_DEPTH);
   localparam int WGT_AW  = $clog2(WGT_DEPTH);
   localparam int BIAS_AW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
   localparam int K_W     = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
   localparam int CI_W    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;

   // product width plus growth over all taps plus room for the bias
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int ACC_W  = PROD_W + $clog2(TAPS + 1) + 2;

   localparam int ACT_W   = 15;
   localparam int ACT_MAX = 32767;
   localparam int SHIFT_W = 5;

   typedef enum logic [1:0] {
      OP_LOAD_FEATURE = 2'd0,
      OP_LOAD_WEIGHT  = 2'd1,
      OP_LOAD_BIAS    = 2'd2,
      OP_COMPUTE      = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RUN   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_BIAS  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   localparam logic CSR_RESULT_SHIFT = 1'b0;

endpackage

### rtl/c2d_ram.sv
// generic single write port, single read port ram with registered read
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/conv2d_bias_relu.sv
// top level: stride-1 valid 2d convolution point with bias, relu, shift and saturation
//
// Loads (feature, weight, bias) go straight into their stores and never
// raise busy. A compute word walks the KERNEL_SIZE^2 * IN_CHANNELS window
// taps through one shared 16x16 multiplier and accumulator, one tap per
// cycle, with the feature and weight stores read one tap ahead; busy stays
// high through the walk, drain, bias and output steps, and the result strobe
// rsp_valid is high for one cycle right after busy falls, in the same cycle
// a new word may already be started. An out-of-range position skips the
// window and the bias and returns 0 from the output step. The receiver cannot
// stall: rsp_activation holds the result until the next output step.
module conv2d_bias_relu (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [9:0]                          req_address,
   input  logic signed [15:0]                  req_data_value,
   input  logic [4:0]                          req_out_row,
   input  logic [4:0]                          req_out_col,
   input  logic [2:0]                          req_out_chan,
   output logic                                rsp_valid,
   output logic [c2d_pkg::ACT_W-1:0]           rsp_activation,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   c2d_pkg::state_type state_ff, state_in;

   logic [c2d_pkg::SHIFT_W-1:0] shift_ff, shift_in;

   logic [4:0]                  row_ff, row_in;
   logic [4:0]                  col_ff, col_in;
   logic [2:0]                  chan_ff, chan_in;
   logic [c2d_pkg::K_W-1:0]     kh_ff, kh_in;
   logic [c2d_pkg::K_W-1:0]     kw_ff, kw_in;
   logic [c2d_pkg::CI_W-1:0]    ci_ff, ci_in;

   logic                        rd_vld_ff, rd_vld_in;
   logic                        mul_vld_ff, mul_vld_in;
   logic signed [c2d_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [c2d_pkg::ACC_W-1:0]  acc_ff, acc_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [c2d_pkg::ACT_W-1:0]   act_ff, act_in;

   logic accept;
   logic is_compute;
   logic pos_ok;
   logic last_tap;
   logic issue;
   logic bias_re;
   logic feat_we, wgt_we, bias_we;
   logic csr_we;

   logic [c2d_pkg::FEAT_AW-1:0]            feat_raddr;
   logic [c2d_pkg::WGT_AW-1:0]             wgt_raddr;
   logic signed [c2d_pkg::DATA_WIDTH-1:0]  feat_rdata;
   logic signed [c2d_pkg::DATA_WIDTH-1:0]  wgt_rdata;
   logic signed [c2d_pkg::DATA_WIDTH-1:0]  bias_rdata;
   logic [c2d_pkg::ACC_W-1:0]              shifted;

   assign accept     = start && (state_ff == c2d_pkg::S_IDLE);
   assign is_compute = (req_operation == c2d_pkg::OP_COMPUTE);
   assign busy       = (state_ff != c2d_pkg::S_IDLE);

   assign pos_ok = (32'(req_out_row) < c2d_pkg::OUT_SIZE)
                && (32'(req_out_col) < c2d_pkg::OUT_SIZE)
                && (32'(req_out_chan) < c2d_pkg::OUT_CHANNELS);

   assign feat_we = accept && (req_operation == c2d_pkg::OP_LOAD_FEATURE)
                 && (32'(req_address) < c2d_pkg::FEAT_DEPTH);
   assign wgt_we  = accept && (req_operation == c2d_pkg::OP_LOAD_WEIGHT)
                 && (32'(req_address) < c2d_pkg::WGT_DEPTH);
   assign bias_we = accept && (req_operation == c2d_pkg::OP_LOAD_BIAS)
                 && (32'(req_address) < c2d_pkg::OUT_CHANNELS);

   assign issue    = (state_ff == c2d_pkg::S_RUN);
   // bias read while draining lands in time for the bias step
   assign bias_re  = (state_ff == c2d_pkg::S_DRAIN);
   assign last_tap = (kh_ff == c2d_pkg::K_W'(c2d_pkg::KERNEL_SIZE - 1))
                  && (kw_ff == c2d_pkg::K_W'(c2d_pkg::KERNEL_SIZE - 1))
                  && (ci_ff == c2d_pkg::CI_W'(c2d_pkg::IN_CHANNELS - 1));

   // tap addresses: feature is row, column, channel; weight is kh, kw, ci, co
   assign feat_raddr = c2d_pkg::FEAT_AW'(
      ((32'(row_ff) + 32'(kh_ff)) * c2d_pkg::IMAGE_SIZE + 32'(col_ff) + 32'(kw_ff))
      * c2d_pkg::IN_CHANNELS + 32'(ci_ff));
   assign wgt_raddr = c2d_pkg::WGT_AW'(
      ((32'(kh_ff) * c2d_pkg::KERNEL_SIZE + 32'(kw_ff)) * c2d_pkg::IN_CHANNELS
       + 32'(ci_ff)) * c2d_pkg::OUT_CHANNELS + 32'(chan_ff));

   c2d_ram #(
      .WIDTH (c2d_pkg::DATA_WIDTH),
      .DEPTH (c2d_pkg::FEAT_DEPTH)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (req_address[c2d_pkg::FEAT_AW-1:0]),
      .wr_data (req_data_value),
      .rd_en   (issue),
      .rd_addr (feat_raddr),
      .rd_data (feat_rdata)
   );

   c2d_ram #(
      .WIDTH (c2d_pkg::DATA_WIDTH),
      .DEPTH (c2d_pkg::WGT_DEPTH)
   ) u_wgt_ram (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_addr (req_address[c2d_pkg::WGT_AW-1:0]),
      .wr_data (req_data_value),
      .rd_en   (issue),
      .rd_addr (wgt_raddr),
      .rd_data (wgt_rdata)
   );

   c2d_ram #(
      .WIDTH (c2d_pkg::DATA_WIDTH),
      .DEPTH (c2d_pkg::OUT_CHANNELS)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (req_address[c2d_pkg::BIAS_AW-1:0]),
      .wr_data (req_data_value),
      .rd_en   (bias_re),
      .rd_addr (chan_ff[c2d_pkg::BIAS_AW-1:0]),
      .rd_data (bias_rdata)
   );

   // configuration port
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;
   assign prdata = (paddr[2] == c2d_pkg::CSR_RESULT_SHIFT)
                 ? {{(32 - c2d_pkg::SHIFT_W){1'b0}}, shift_ff} : 32'd0;

   always_comb begin
      shift_in = shift_ff;
      if (csr_we && (paddr[2] == c2d_pkg::CSR_RESULT_SHIFT)) begin
         shift_in = pwdata[c2d_pkg::SHIFT_W-1:0];
      end
   end

   assign shifted = $unsigned(acc_ff) >> shift_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      chan_in      = chan_ff;
      kh_in        = kh_ff;
      kw_in        = kw_ff;
      ci_in        = ci_ff;
      rd_vld_in    = 1'b0;
      mul_vld_in   = rd_vld_ff;
      prod_in      = feat_rdata * wgt_rdata;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      act_in       = act_ff;

      if (mul_vld_ff) begin
         acc_in = acc_ff + c2d_pkg::ACC_W'(prod_ff);
      end

      case (state_ff)
         c2d_pkg::S_IDLE: begin
            if (accept && is_compute) begin
               row_in  = req_out_row;
               col_in  = req_out_col;
               chan_in = req_out_chan;
               kh_in   = '0;
               kw_in   = '0;
               ci_in   = '0;
               acc_in  = '0;
               // out-of-range position answers 0 without touching the window
               state_in = pos_ok ? c2d_pkg::S_RUN : c2d_pkg::S_OUT;
            end
         end
         c2d_pkg::S_RUN: begin
            rd_vld_in = 1'b1;
            if (last_tap) begin
               state_in = c2d_pkg::S_DRAIN;
            end else if (ci_ff != c2d_pkg::CI_W'(c2d_pkg::IN_CHANNELS - 1)) begin
               ci_in = ci_ff + 1'b1;
            end else begin
               ci_in = '0;
               if (kw_ff != c2d_pkg::K_W'(c2d_pkg::KERNEL_SIZE - 1)) begin
                  kw_in = kw_ff + 1'b1;
               end else begin
                  kw_in = '0;
                  kh_in = kh_ff + 1'b1;
               end
            end
         end
         c2d_pkg::S_DRAIN: begin
            // last product lands in the accumulator before the bias step
            if (!rd_vld_ff) begin
               state_in = c2d_pkg::S_BIAS;
            end
         end
         c2d_pkg::S_BIAS: begin
            acc_in   = acc_ff + c2d_pkg::ACC_W'(bias_rdata);
            state_in = c2d_pkg::S_OUT;
         end
         c2d_pkg::S_OUT: begin
            rsp_valid_in = 1'b1;
            if (acc_ff[c2d_pkg::ACC_W-1]) begin
               act_in = '0;
            end else if (shifted > c2d_pkg::ACC_W'(c2d_pkg::ACT_MAX)) begin
               act_in = c2d_pkg::ACT_W'(c2d_pkg::ACT_MAX);
            end else begin
               act_in = shifted[c2d_pkg::ACT_W-1:0];
            end
            state_in = c2d_pkg::S_IDLE;
         end
         default: begin
            state_in = c2d_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c2d_pkg::S_IDLE;
         shift_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      chan_ff <= chan_in;
      kh_ff   <= kh_in;
      kw_ff   <= kw_in;
      ci_ff   <= ci_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      act_ff  <= act_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = act_ff;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == c2d_pkg::S_OUT))
      else $error("result strobe without an output step");

   a_read_in_window : assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == c2d_pkg::S_RUN || state_ff == c2d_pkg::S_DRAIN))
      else $error("tap read outside the window walk");

   a_compute_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && is_compute) |=> busy)
      else $error("compute word did not raise busy");

endmodule
